FILE: rtl/sida_pkg.sv
package sida_pkg;

   // Character encoding of the result items
   localparam int CHAR_W = 6;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

   // Binary to BCD shift-and-add-3 conversion
   localparam int DIGIT_W = 4;
   localparam int BITS_PER_STEP = 4;
   localparam logic [DIGIT_W-1:0] DABBLE_THRESHOLD = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

endpackage

FILE: rtl/sida_if.sv
interface sida_req_if #(parameter int VALUE_BITS = 32) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sida_rsp_if ();
   logic                            valid;
   logic                            ready;
   logic [sida_pkg::CHAR_W-1:0]     char_code;
   logic                            last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/sida_queue.sv
module sida_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/sida_front.sv
module sida_front #(
   parameter int VALUE_BITS = 32
) (
   sida_req_if.sink               req_ch,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic                   push_neg,
   output logic [VALUE_BITS-1:0]  push_mag
);

   logic neg;

   // Classify sign and take the unsigned magnitude; the most negative value
   // maps onto 2^(VALUE_BITS-1) on its own
   assign neg        = req_ch.value[VALUE_BITS-1];
   assign push_neg   = neg;
   assign push_mag   = neg ? (~req_ch.value + 1'b1) : req_ch.value;
   assign push_valid = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

FILE: rtl/sida_back.sv
module sida_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic                   pop_neg,
   input  logic [VALUE_BITS-1:0]  pop_mag,
   sida_rsp_if.source             rsp_ch
);

   localparam int DIGIT_W    = sida_pkg::DIGIT_W;
   localparam int CHAR_W     = sida_pkg::CHAR_W;
   localparam int BPS        = sida_pkg::BITS_PER_STEP;
   localparam int STEPS      = (VALUE_BITS + BPS - 1) / BPS;
   localparam int PAD_W      = STEPS * BPS;
   localparam int MAX_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int STEP_W     = $clog2(STEPS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_FIND = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

   back_state_type                       state_ff, state_in;
   logic [PAD_W-1:0]                     bin_ff, bin_in;
   logic [MAX_DIGITS-1:0][DIGIT_W-1:0]   bcd_ff, bcd_in;
   logic [STEP_W-1:0]                    step_ff, step_in;
   logic                                 neg_ff, neg_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]                    char_ff, char_in;
   logic                                 last_ff, last_in;

   logic [MAX_DIGITS-1:0][DIGIT_W-1:0]   dab_bcd;
   logic [PAD_W-1:0]                     dab_bin;
   logic [IDX_W-1:0]                     lead;
   logic                                 slot_free;

   // Shift in BPS magnitude bits, adding 3 to every digit of 5 or more first
   always_comb begin
      logic [MAX_DIGITS-1:0][DIGIT_W-1:0] b;
      logic [BCD_W-1:0]                   flat;
      logic [PAD_W-1:0]                   s;
      logic [DIGIT_W-1:0]                 d;
      b = bcd_ff;
      s = bin_ff;
      for (int k = 0; k < BPS; k++) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            d = b[i];
            if (d >= sida_pkg::DABBLE_THRESHOLD) begin
               b[i] = d + sida_pkg::DABBLE_ADJUST;
            end
         end
         flat = b;
         flat = {flat[BCD_W-2:0], s[PAD_W-1]};
         b = flat;
         s = {s[PAD_W-2:0], 1'b0};
      end
      dab_bcd = b;
      dab_bin = s;
   end

   // Find the most significant nonzero digit; zero leaves index 0
   always_comb begin
      lead = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            lead = IDX_W'(i);
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready = (state_ff == ST_IDLE);

   // Sequence: load, convert, find leading digit, emit characters
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               bin_in   = PAD_W'(pop_mag);
               bcd_in   = '0;
               step_in  = '0;
               neg_in   = pop_neg;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bin_in  = dab_bin;
            bcd_in  = dab_bcd;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = lead;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  char_in = sida_pkg::ASCII_MINUS;
                  last_in = 1'b0;
                  neg_in  = 1'b0;
               end else begin
                  char_in = sida_pkg::ASCII_ZERO
                            + {{(CHAR_W - DIGIT_W){1'b0}}, bcd_ff[idx_ff]};
                  last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.char_code = char_ff;
   assign rsp_ch.last_char = last_ff;

endmodule

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// Prints one signed VALUE_BITS-bit integer per req_ch item as decimal ASCII text on rsp_ch,
// one character per item, most significant first, a minus sign ahead of negative values,
// no leading zeros, and last_char set on the final character. A two-entry queue takes
// new items while the converter works. Each number goes through shift-and-add-3
// conversion (four bits per cycle), a state that locates the leading digit, its
// characters one by one as the output takes them, and a return to idle that takes the
// next number from the queue; the conversion loop and the single character output
// port limit the throughput.
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   sida_req_if.sink    req_ch,
   sida_rsp_if.source  rsp_ch
);

   logic                  push_valid;
   logic                  push_ready;
   logic                  push_neg;
   logic [VALUE_BITS-1:0] push_mag;
   logic                  pop_valid;
   logic                  pop_ready;
   logic                  pop_neg;
   logic [VALUE_BITS-1:0] pop_mag;

   sida_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_neg   (push_neg),
      .push_mag   (push_mag)
   );

   sida_queue #(
      .WIDTH (VALUE_BITS + 1),
      .DEPTH (sida_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_neg, push_mag}),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  ({pop_neg, pop_mag})
   );

   sida_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_neg   (pop_neg),
      .pop_mag   (pop_mag),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: rtl/sida_checker.sv
module sida_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sida_pkg::CHAR_W-1:0] rsp_char_code,
   input logic                        rsp_last_char
);

   logic lead_ff, lead_in;

   // Mark the next character as leading a number: after a last character or a minus sign
   always_comb begin
      lead_in = lead_ff;
      if (rsp_valid && rsp_ready) begin
         lead_in = rsp_last_char || (rsp_char_code == sida_pkg::ASCII_MINUS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 1'b1;
      end else begin
         lead_ff <= lead_in;
      end
   end

   // Drop any pending item on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item pending after reset");

   // Hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code)
                                  && $stable(rsp_last_char))
      else $error("stalled result item changed");

   // Only a minus sign or a digit, and a minus sign never ends a number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == sida_pkg::ASCII_MINUS && !rsp_last_char)
                    || (rsp_char_code >= sida_pkg::ASCII_ZERO
                        && rsp_char_code <= sida_pkg::ASCII_NINE))
      else $error("bad character code");

   // A leading zero stands only for the number zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && lead_ff && rsp_char_code == sida_pkg::ASCII_ZERO |-> rsp_last_char)
      else $error("leading zero in decimal text");

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_char_code (rsp_ch.char_code),
   .rsp_last_char (rsp_ch.last_char)
);

FILE: tb/sv/signed_int_to_decimal_ascii_top_test.sv
module signed_int_to_decimal_ascii_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_BITS = 32;
   localparam int DIRECTED_COUNT = 20;
   localparam int RANDOM_NUMBERS = 320;
   localparam int IDLE_PCT = 33;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_CHAR = 150;
   localparam int DRAIN_CYCLES = 40;
   // numbers and characters sent with no idling at all
   localparam int STEADY_FIRST = 120;
   localparam int STEADY_LAST = 200;
   localparam int STEADY_CHAR_FIRST = 1000;
   localparam int STEADY_CHAR_LAST = 1600;

   typedef struct packed {
      logic [sida_pkg::CHAR_W-1:0] char_code;
      logic                        last_char;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sida_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   sida_rsp_if rsp_ch ();

   signed_int_to_decimal_ascii_top #(.VALUE_BITS(VALUE_BITS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // characters still owed by the block, oldest first
   text_char_type expected_chars[$];
   int unsigned error_count = 0;
   int unsigned numbers_sent = 0;
   int unsigned negatives_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   // directed numbers; text is filled in only where it is obvious
   localparam logic signed [VALUE_BITS-1:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
      0, 1, -1, 9, -9, 10, -10, 99, -100, 2147483647,
      32'sh8000_0000, 2147483646, -2147483647, 1000000000, -999999999,
      32'sh5555_5555, 32'shAAAA_AAAA, 123456789, -987654321, 100000
   };
   string directed_text [DIRECTED_COUNT] = '{
      "0", "1", "-1", "9", "-9", "10", "-10", "99", "-100", "2147483647",
      "-2147483648", "2147483646", "-2147483647", "1000000000", "-999999999",
      "", "", "", "", ""
   };

   // Queue the decimal text of one number: sign first, then digits
   task automatic predict_decimal_text(input logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] remaining;
      logic [3:0]            digits [10];
      int                    count;
      remaining = value[VALUE_BITS-1] ? ~value + 1'b1 : value;
      count = 0;
      do begin
         digits[count] = 4'(remaining % 10);
         count++;
         remaining = remaining / 10;
      end while (remaining != 0);
      if (value[VALUE_BITS-1]) begin
         expected_chars.push_back(text_char_type'{sida_pkg::ASCII_MINUS, 1'b0});
      end
      for (int i = count - 1; i >= 0; i--) begin
         expected_chars.push_back(text_char_type'{
            sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(digits[i]), i == 0});
      end
   endtask

   // Queue a text written out by hand
   task automatic queue_written_text(input string text);
      byte code;
      for (int i = 0; i < text.len(); i++) begin
         code = text[i];
         expected_chars.push_back(text_char_type'{code[sida_pkg::CHAR_W-1:0],
                                                  i == text.len() - 1});
      end
   endtask

   // Offer one number, idling first at random when allow_gaps is set, and hold until taken
   task automatic send_number(input logic signed [VALUE_BITS-1:0] value, input bit allow_gaps);
      while (allow_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      numbers_sent++;
      if (value < 0) negatives_sent++;
   endtask

   // Mix full-range values, short magnitudes, powers of ten and the extremes
   function automatic logic signed [VALUE_BITS-1:0] random_number();
      logic [VALUE_BITS-1:0] bits;
      longint                power;
      int                    width;
      bits = $urandom;
      case ($urandom_range(5))
         0: begin
         end
         1, 2: begin
            width = $urandom_range(1, VALUE_BITS - 1);
            bits = VALUE_BITS'(bits & ((64'd1 << width) - 1));
            if ($urandom_range(1)) bits = ~bits + 1'b1;
         end
         3: begin
            power = 1;
            repeat ($urandom_range(9)) power *= 10;
            bits = VALUE_BITS'(power + $urandom_range(2) - 1);
            if ($urandom_range(1)) bits = ~bits + 1'b1;
         end
         4: bits = $urandom_range(40) - 20;
         default: begin
            if ($urandom_range(1)) bits = 32'h8000_0000 + $urandom_range(3);
            else bits = 32'h7FFF_FFFF - $urandom_range(3);
         end
      endcase
      return bits;
   endfunction

   // Stimulus: directed rows, then random numbers, then drain
   initial begin
      logic signed [VALUE_BITS-1:0] value;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_number(DIRECTED_VALUES[i], 1'b1);
         if (directed_text[i] == "") predict_decimal_text(DIRECTED_VALUES[i]);
         else queue_written_text(directed_text[i]);
      end

      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         value = random_number();
         send_number(value, !(i >= STEADY_FIRST && i < STEADY_LAST));
         predict_decimal_text(value);
      end
      req_ch.valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d numbers converted (%0d directed, %0d negative), %0d characters checked",
               numbers_sent, DIRECTED_COUNT, negatives_sent, chars_checked);
      $display("including both extremes, zero and one long output stall; %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Check each character taken and drive ready for the next cycle
   always @(posedge clock) begin : check_chars
      text_char_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_chars.size() == 0) begin
               error_count++;
               $display("%0t: unexpected character: expected none, got code %0d last %0b",
                        $time, rsp_ch.char_code, rsp_ch.last_char);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ch.char_code !== want.char_code) begin
                  error_count++;
                  $display("%0t: char_code mismatch: expected %0d, got %0d",
                           $time, want.char_code, rsp_ch.char_code);
               end
               if (rsp_ch.last_char !== want.last_char) begin
                  error_count++;
                  $display("%0t: last_char mismatch: expected %0b, got %0b",
                           $time, want.last_char, rsp_ch.last_char);
               end
            end
            chars_checked++;
         end

         // hold off once for a long stretch so the block backs up
         if (!hold_done && chars_checked >= HOLD_AT_CHAR) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (chars_checked >= STEADY_CHAR_FIRST && chars_checked < STEADY_CHAR_LAST) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d characters still owed",
                  $time, QUIET_LIMIT, expected_chars.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: signed_int_to_decimal_ascii_top.f
rtl/sida_pkg.sv
rtl/sida_if.sv
rtl/sida_queue.sv
rtl/sida_front.sv
rtl/sida_back.sv
rtl/signed_int_to_decimal_ascii_top.sv
rtl/sida_checker.sv
tb/sv/signed_int_to_decimal_ascii_top_test.sv
